FILE: sv/mws_pkg.sv
// Shared types and constants for the max window sum block.
package mws_pkg;

	localparam int SUM_W        = 20;
	localparam int OUT_TDATA_W  = 24;
	localparam int GRID_ROWS_W  = 11;
	localparam int GRID_COLS_W  = 11;
	localparam int WIN_ROWS_W   = 7;
	localparam int WIN_COLS_W   = 11;
	localparam int CFG_DATA_W   = 11;
	localparam int CFG_IDX_W    = 2;
	localparam int MAX_ROWS     = 1024;
	localparam int ROW_W        = 10;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GRID_ROWS = 2'd0,
		REG_GRID_COLS = 2'd1,
		REG_WIN_ROWS  = 2'd2,
		REG_WIN_COLS  = 2'd3
	} cfg_reg_t;

	// Per-item flags that ride along with the column sum into the window stage.
	typedef struct packed {
		logic fits;       // a window fits the configured grid
		logic in_window;  // enough rows seen for a full window height
		logic col0;       // first column of the row
		logic sub_old;    // a column sum leaves the horizontal window
		logic full;       // horizontal window is complete
		logic last;       // last cell of the grid
	} mws_ctrl_t;

endpackage

FILE: sv/mws_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module mws_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Read returns the old contents when read and write hit the same entry.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: sv/mws_ring_div.sv
// Restoring remainder unit: row index modulo window height, one bit per cycle.
module mws_ring_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [mws_pkg::ROW_W-1:0]       dividend,
	input  logic [mws_pkg::WIN_ROWS_W-1:0]  divisor,
	output logic                            busy,
	output logic                            done,
	output logic [mws_pkg::WIN_ROWS_W-1:0]  rem
);
	import mws_pkg::*;

	localparam int CNT_W = $clog2(ROW_W + 1);

	logic                  busy_q;
	logic                  done_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [ROW_W-1:0]      shift_q;
	logic [WIN_ROWS_W-1:0] rem_q;
	logic [WIN_ROWS_W:0]   trial;

	assign trial = {rem_q, shift_q[ROW_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(ROW_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			shift_q <= dividend;
			rem_q   <= '0;
		end else if (busy_q) begin
			shift_q <= shift_q << 1;
			if (trial >= {1'b0, divisor}) begin
				rem_q <= WIN_ROWS_W'(trial - {1'b0, divisor});
			end else begin
				rem_q <= trial[WIN_ROWS_W-1:0];
			end
		end
	end

	assign busy = busy_q | done_q;
	assign done = done_q;
	assign rem  = rem_q;

endmodule

FILE: sv/mws_window.sv
// Horizontal window sum and running maximum over incoming column sums.
module mws_window #(
	parameter int CS_W = 10
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       valid,
	input  mws_pkg::mws_ctrl_t         ctrl,
	input  logic [CS_W-1:0]            col_sum,
	input  logic [CS_W-1:0]            old_sum,
	output logic                       res_valid,
	output logic [mws_pkg::SUM_W-1:0]  res_sum
);
	import mws_pkg::*;

	logic [SUM_W-1:0] ws_q;
	logic [SUM_W-1:0] best_q;
	logic [SUM_W-1:0] ws_base;
	logic [SUM_W-1:0] ws_new;
	logic [SUM_W-1:0] best_new;
	logic             upd;

	always_comb begin
		ws_base  = ctrl.col0 ? '0 : ws_q;
		ws_new   = ws_base + SUM_W'(col_sum) - (ctrl.sub_old ? SUM_W'(old_sum) : '0);
		upd      = valid && ctrl.fits && ctrl.in_window;
		best_new = (upd && ctrl.full && (ws_new > best_q)) ? ws_new : best_q;
	end

	assign res_valid = valid && ctrl.last;
	assign res_sum   = ctrl.fits ? best_new : '0;

	// Clear both sums at grid end so the next grid starts fresh.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ws_q   <= '0;
			best_q <= '0;
		end else if (valid && ctrl.last) begin
			ws_q   <= '0;
			best_q <= '0;
		end else if (upd) begin
			ws_q   <= ws_new;
			best_q <= best_new;
		end
	end

endmodule

FILE: sv/max_window_sum_2d.sv
// Top level of the maximum fixed-size window sum engine.
//
// Grid cells stream in row-major order on the slave side, one cell value per
// transaction; on the grid's last cell one transaction on the master side
// carries the largest sum over all windows of win_rows x win_cols that lie
// fully inside the grid, or 0 when no window fits. State lives in three
// synchronous RAMs: a line store of the last win_rows rows (MAX_WIN_ROWS x
// MAX_COLS cells) and two identical copies of the per-column sums, one read
// at the current column and one at the column leaving the horizontal window.
// Each cell is handled by a read / modify / write-back pipeline: the address
// stage reads the RAMs, the next stage forms the new column sum and writes it
// back (forwarding the previous cell's write when it hits the same entry),
// and the last stage updates the horizontal sum and the running maximum.
// Throughput is one cell per clock while s_tready is high. A grid-ending cell
// waits while an earlier result is still in the pipeline or unaccepted in the
// output register, so a 1x1 grid takes no new cell until the last result has
// been accepted. The result passes through the s1, s2 and output registers
// after its last cell is accepted. Every configuration write stalls the input
// while the line store row slot (row index modulo window height) is
// recomputed by a bit-serial remainder unit. The RAMs need no clearing after
// reset; entries are always written before the grid reads them.
module max_window_sum_2d #(
	parameter int MAX_COLS     = 1024,
	parameter int MAX_WIN_ROWS = 64,
	parameter int VALUE_BITS   = 4
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// cell stream
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [((VALUE_BITS+7)/8)*8-1:0]     s_tdata,   // [VALUE_BITS-1:0] cell_value
	// result stream
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [mws_pkg::OUT_TDATA_W-1:0]     m_tdata,   // [19:0] max_sum
	// configuration
	input  logic                                cfg_we,
	input  logic [mws_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [mws_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
	import mws_pkg::*;

	localparam int CW       = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int COLS_W   = $clog2(MAX_COLS + 1);
	localparam int CMP_W    = ((COLS_W > WIN_COLS_W) ? COLS_W : WIN_COLS_W) + 1;
	localparam int RING_W   = (MAX_WIN_ROWS > 1) ? $clog2(MAX_WIN_ROWS) : 1;
	localparam int LS_DEPTH = MAX_WIN_ROWS * MAX_COLS;
	localparam int LS_AW    = (LS_DEPTH > 1) ? $clog2(LS_DEPTH) : 1;
	localparam int CS_W     = $clog2(MAX_WIN_ROWS * ((1 << VALUE_BITS) - 1) + 1);

	// ---------------------------------------------------------------------
	// Configuration registers; grid sizes are clamped on write.
	// ---------------------------------------------------------------------
	logic [GRID_ROWS_W-1:0] rows_q;
	logic [COLS_W-1:0]      cols_q;
	logic [WIN_ROWS_W-1:0]  wr_q;
	logic [WIN_COLS_W-1:0]  wc_q;
	logic                   fits_q;
	logic [GRID_ROWS_W-1:0] rows_clamped;
	logic [COLS_W-1:0]      cols_clamped;
	logic                   fits_d;

	always_comb begin
		if (cfg_wdata == '0) begin
			rows_clamped = GRID_ROWS_W'(1);
		end else if (32'(cfg_wdata) > MAX_ROWS) begin
			rows_clamped = GRID_ROWS_W'(MAX_ROWS);
		end else begin
			rows_clamped = GRID_ROWS_W'(cfg_wdata);
		end
		if (cfg_wdata == '0) begin
			cols_clamped = COLS_W'(1);
		end else if (32'(cfg_wdata) > MAX_COLS) begin
			cols_clamped = COLS_W'(MAX_COLS);
		end else begin
			cols_clamped = COLS_W'(cfg_wdata);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= GRID_ROWS_W'(1);
			cols_q <= COLS_W'(1);
			wr_q   <= WIN_ROWS_W'(1);
			wc_q   <= WIN_COLS_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_GRID_ROWS: rows_q <= rows_clamped;
				REG_GRID_COLS: cols_q <= cols_clamped;
				REG_WIN_ROWS:  wr_q   <= cfg_wdata[WIN_ROWS_W-1:0];
				REG_WIN_COLS:  wc_q   <= cfg_wdata[WIN_COLS_W-1:0];
			endcase
		end
	end

	// A window fits when both its sides are nonzero, its height is at most MAX_WIN_ROWS and it lies inside the grid.
	assign fits_d = (wr_q != '0) && (32'(wr_q) <= MAX_WIN_ROWS) &&
		(GRID_ROWS_W'(wr_q) <= rows_q) && (wc_q != '0) &&
		(CMP_W'(wc_q) <= CMP_W'(cols_q));

	// Settles long before the input reopens after a write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fits_q <= 1'b1;
		end else begin
			fits_q <= fits_d;
		end
	end

	// ---------------------------------------------------------------------
	// Position counters and the line store row slot.
	// ---------------------------------------------------------------------
	logic [ROW_W-1:0]      row_q;
	logic [CW-1:0]         col_q;
	logic [RING_W-1:0]     ring_q;
	logic                  div_busy;
	logic                  div_done;
	logic [WIN_ROWS_W-1:0] div_rem;

	// Recompute the slot after any configuration write.
	mws_ring_div u_ring_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cfg_we),
		.dividend (row_q),
		.divisor  (wr_q),
		.busy     (div_busy),
		.done     (div_done),
		.rem      (div_rem)
	);

	// ---------------------------------------------------------------------
	// Address stage (s0): decode position, issue RAM reads.
	// ---------------------------------------------------------------------
	logic [CMP_W-1:0]  c_ext;
	logic [CMP_W-1:0]  wc_ext;
	logic [CMP_W-1:0]  cdiff;
	logic              row_end;
	logic              grid_end;
	logic              ring_wrap;
	logic [RING_W-1:0] ring_next;
	logic [LS_AW-1:0]  slot0;
	logic [CW-1:0]     addr_b0;
	mws_ctrl_t         ctrl0;
	logic              has_leave0;
	logic              first_row0;
	logic              accept;
	logic              result_pending;

	// Stage registers declared ahead of use.
	logic                  valid_s1;
	logic [VALUE_BITS-1:0] v_s1;
	logic [CW-1:0]         col_s1;
	logic [LS_AW-1:0]      slot_s1;
	logic                  has_leave_s1;
	logic                  first_row_s1;
	logic                  fwd_l_s1;
	logic                  fwd_a_s1;
	logic                  fwd_b_s1;
	mws_ctrl_t             ctrl_s1;

	logic                  valid_s2;
	logic [VALUE_BITS-1:0] v_s2;
	logic [CS_W-1:0]       cs_s2;
	logic [CS_W-1:0]       old_b_s2;
	mws_ctrl_t             ctrl_s2;

	logic                  m_tvalid_q;
	logic [SUM_W-1:0]      m_data_q;

	always_comb begin
		c_ext      = CMP_W'(col_q);
		wc_ext     = CMP_W'(wc_q);
		cdiff      = c_ext - wc_ext;
		addr_b0    = cdiff[CW-1:0];
		row_end    = (c_ext + CMP_W'(1)) >= CMP_W'(cols_q);
		grid_end   = row_end && ((GRID_ROWS_W'(row_q) + GRID_ROWS_W'(1)) >= rows_q);
		ring_wrap  = (GRID_ROWS_W'(ring_q) + GRID_ROWS_W'(1)) >= GRID_ROWS_W'(wr_q);
		ring_next  = ring_wrap ? '0 : ring_q + 1'b1;
		slot0      = LS_AW'(32'(ring_q) * MAX_COLS + 32'(col_q));
		has_leave0 = GRID_ROWS_W'(row_q) >= GRID_ROWS_W'(wr_q);
		first_row0 = (row_q == '0);

		ctrl0.fits      = fits_q;
		ctrl0.in_window = (GRID_ROWS_W'(row_q) + GRID_ROWS_W'(1)) >= GRID_ROWS_W'(wr_q);
		ctrl0.col0      = (col_q == '0);
		ctrl0.sub_old   = c_ext >= wc_ext;
		ctrl0.full      = (c_ext + CMP_W'(1)) >= wc_ext;
		ctrl0.last      = grid_end;
	end

	// Only one result may be in flight; a grid-ending cell waits for the slot.
	assign result_pending = (valid_s1 && ctrl_s1.last) || (valid_s2 && ctrl_s2.last) ||
		m_tvalid_q;
	assign s_tready = !div_busy && !cfg_we && !(grid_end && result_pending);
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q  <= '0;
			col_q  <= '0;
			ring_q <= '0;
		end else if (div_done) begin
			ring_q <= RING_W'(div_rem);
		end else if (accept) begin
			if (row_end) begin
				col_q <= '0;
				if (grid_end) begin
					row_q  <= '0;
					ring_q <= '0;
				end else begin
					row_q  <= row_q + 1'b1;
					ring_q <= ring_next;
				end
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------------
	// Read / modify / write stage (s1).
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	// The previous cell writes back at the same edge these reads sample,
	// so flag a hit and take its data from s2 instead of the RAM.
	always_ff @(posedge clk) begin
		v_s1         <= s_tdata[VALUE_BITS-1:0];
		col_s1       <= col_q;
		slot_s1      <= slot0;
		has_leave_s1 <= has_leave0;
		first_row_s1 <= first_row0;
		ctrl_s1      <= ctrl0;
		fwd_l_s1     <= valid_s1 && ctrl_s1.fits && (slot0 == slot_s1);
		fwd_a_s1     <= valid_s1 && ctrl_s1.fits && (col_q == col_s1);
		fwd_b_s1     <= valid_s1 && ctrl_s1.fits && (addr_b0 == col_s1);
	end

	logic [VALUE_BITS-1:0] line_rd;
	logic [CS_W-1:0]       csa_rd;
	logic [CS_W-1:0]       csb_rd;
	logic [VALUE_BITS-1:0] leave_s1;
	logic [CS_W-1:0]       cs_base_s1;
	logic [CS_W-1:0]       cs_s1;
	logic [CS_W-1:0]       old_b_s1;
	logic                  wr_en_s1;

	always_comb begin
		leave_s1   = has_leave_s1 ? (fwd_l_s1 ? v_s2 : line_rd) : '0;
		cs_base_s1 = first_row_s1 ? '0 : (fwd_a_s1 ? cs_s2 : csa_rd);
		cs_s1      = cs_base_s1 + CS_W'(v_s1) - CS_W'(leave_s1);
		old_b_s1   = fwd_b_s1 ? cs_s2 : csb_rd;
		wr_en_s1   = valid_s1 && ctrl_s1.fits;
	end

	mws_ram #(
		.WIDTH (VALUE_BITS),
		.DEPTH (LS_DEPTH)
	) u_line_store (
		.clk   (clk),
		.we    (wr_en_s1),
		.waddr (slot_s1),
		.wdata (v_s1),
		.raddr (slot0),
		.rdata (line_rd)
	);

	mws_ram #(
		.WIDTH (CS_W),
		.DEPTH (MAX_COLS)
	) u_colsum_cur (
		.clk   (clk),
		.we    (wr_en_s1),
		.waddr (col_s1),
		.wdata (cs_s1),
		.raddr (col_q),
		.rdata (csa_rd)
	);

	mws_ram #(
		.WIDTH (CS_W),
		.DEPTH (MAX_COLS)
	) u_colsum_old (
		.clk   (clk),
		.we    (wr_en_s1),
		.waddr (col_s1),
		.wdata (cs_s1),
		.raddr (addr_b0),
		.rdata (csb_rd)
	);

	// ---------------------------------------------------------------------
	// Window stage (s2).
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		v_s2     <= v_s1;
		cs_s2    <= cs_s1;
		old_b_s2 <= old_b_s1;
		ctrl_s2  <= ctrl_s1;
	end

	logic             res_valid;
	logic [SUM_W-1:0] res_sum;

	mws_window #(
		.CS_W (CS_W)
	) u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid     (valid_s2),
		.ctrl      (ctrl_s2),
		.col_sum   (cs_s2),
		.old_sum   (old_b_s2),
		.res_valid (res_valid),
		.res_sum   (res_sum)
	);

	// ---------------------------------------------------------------------
	// Output register; hold the result until the sink takes it.
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_valid) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			m_data_q <= res_sum;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = OUT_TDATA_W'(m_data_q);

	// ---------------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------------
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		$countones({valid_s1 && ctrl_s1.last, valid_s2 && ctrl_s2.last, m_tvalid_q}) <= 1)
		else $error("more than one result in flight");

	a_out_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && ctrl_s2.last |-> !m_tvalid_q)
		else $error("result reached a full output register");

	a_ring_range: assert property (@(posedge clk) disable iff (!arst_n)
		!div_busy && fits_q |-> GRID_ROWS_W'(ring_q) < GRID_ROWS_W'(wr_q))
		else $error("row slot outside the window height");

	a_grid_restart: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && ctrl_s1.last |-> (row_q == '0) && (col_q == '0))
		else $error("position not rewound after grid end");

endmodule
